[sv/keyboard_packet_scancode_decoder_core_assert.svh]
// Assertion macros for the scancode decoder
`ifndef KEYBOARD_PACKET_SCANCODE_DECODER_CORE_ASSERT_SVH
`define KEYBOARD_PACKET_SCANCODE_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define KPSD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("kpsd assertion failed");
`define KPSD_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("kpsd assertion failed");
`else
`define KPSD_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define KPSD_ASSERT_NXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

[sv/kpsd_pkg.sv]
package kpsd_pkg;

    localparam int unsigned SCANCODES = 128;
    localparam int unsigned KEY_W     = $clog2(SCANCODES);

    localparam logic [7:0] HDR_MIN     = 8'hF6;
    localparam logic [7:0] HDR_STATUS  = 8'hF6;
    localparam logic [7:0] HDR_CLOCK   = 8'hFC;

    localparam logic [KEY_W-1:0] SC_LSHIFT = 7'h2A;
    localparam logic [KEY_W-1:0] SC_RSHIFT = 7'h36;
    localparam logic [KEY_W-1:0] SC_CTRL   = 7'h1D;
    localparam logic [KEY_W-1:0] SC_ALT    = 7'h38;
    localparam logic [KEY_W-1:0] SC_CAPS   = 7'h3A;

    localparam logic       KIND_CHAR  = 1'b0;
    localparam logic       KIND_REPLY = 1'b1;

    typedef struct packed {
        logic key_evt;   // byte is a key press or release
        logic reply;     // status or clock reply finished with this byte
    } t_frame_ev;

    localparam logic [7:0] PLAIN_MAP [SCANCODES] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h88, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94,
        8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h00, 8'h00, 8'h84,
        8'h80, 8'h00, 8'h2D, 8'h82, 8'h00, 8'h83, 8'h2B, 8'h00,
        8'h81, 8'h00, 8'h85, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h86, 8'h87, 8'h28, 8'h2F, 8'h2A, 8'h29, 8'h37,
        8'h38, 8'h39, 8'h34, 8'h35, 8'h36, 8'h31, 8'h32, 8'h33,
        8'h30, 8'h2E, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFT_MAP [SCANCODES] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h88, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94,
        8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h00, 8'h00, 8'h84,
        8'h80, 8'h00, 8'h2D, 8'h82, 8'h00, 8'h83, 8'h2B, 8'h00,
        8'h81, 8'h00, 8'h85, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h86, 8'h87, 8'h28, 8'h2F, 8'h2A, 8'h29, 8'h37,
        8'h38, 8'h39, 8'h34, 8'h35, 8'h36, 8'h31, 8'h32, 8'h33,
        8'h30, 8'h2E, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // total packet length, header included
    function automatic logic [3:0] pkt_len(input logic [3:0] idx);
        logic [3:0] len;
        case (idx)
            4'd0:    len = 4'd8;
            4'd1:    len = 4'd6;
            4'd6:    len = 4'd7;
            4'd7:    len = 4'd3;
            4'd8:    len = 4'd2;
            4'd9:    len = 4'd2;
            default: len = 4'd3;
        endcase
        return len;
    endfunction

    function automatic logic is_mod(input logic [KEY_W-1:0] k);
        return (k == SC_LSHIFT) || (k == SC_RSHIFT) || (k == SC_CTRL) ||
               (k == SC_ALT) || (k == SC_CAPS);
    endfunction

endpackage

[sv/kpsd_framer.sv]
module kpsd_framer import kpsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    output t_frame_ev  o_ev
);

    logic [7:0] r_hdr, n_hdr;
    logic [3:0] r_taken, n_taken;
    logic [3:0] r_len, n_len;
    logic [3:0] w_inc;

    assign w_inc = r_taken + 4'd1;

    always_comb begin
        n_hdr      = r_hdr;
        n_taken    = r_taken;
        n_len      = r_len;
        o_ev       = '0;
        if (r_taken == 4'd0) begin
            if (i_byte < HDR_MIN) begin
                o_ev.key_evt = 1'b1;
            end else begin
                n_hdr   = i_byte;
                n_len   = pkt_len(i_byte[3:0] - HDR_MIN[3:0]);
                n_taken = 4'd1;
            end
        end else if (w_inc < r_len) begin
            n_taken = w_inc;
        end else begin
            n_taken  = 4'd0;
            n_len    = 4'd1;
            o_ev.reply = (r_hdr == HDR_STATUS) || (r_hdr == HDR_CLOCK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= '0;
            r_taken <= '0;
            r_len   <= 4'd1;
        end else if (i_adv) begin
            r_hdr   <= n_hdr;
            r_taken <= n_taken;
            r_len   <= n_len;
        end
    end

endmodule

[sv/kpsd_keymap.sv]
module kpsd_keymap import kpsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_key_evt,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output logic [7:0] o_char
);

    logic [SCANCODES-1:0] r_map, n_map;
    logic [KEY_W-1:0]     r_last, n_last;
    logic signed [7:0]    r_cnt, n_cnt;
    logic                 r_caps, n_caps;
    logic [KEY_W-1:0]     w_k;
    logic                 w_rel;
    logic                 w_mod;
    logic [7:0]           w_ch;

    assign w_k   = i_byte[KEY_W-1:0];
    assign w_rel = i_byte[7];
    assign w_mod = is_mod(w_k);

    always_comb begin
        n_map  = r_map;
        n_last = r_last;
        n_cnt  = r_cnt;
        n_caps = r_caps;
        o_emit = 1'b0;
        if (w_rel) begin
            n_map[w_k] = 1'b0;
            if (!w_mod && r_cnt != -8'sd128) n_cnt = r_cnt - 8'sd1;
            if (w_k == r_last) n_last = '0;
        end else begin
            n_map[w_k] = 1'b1;
            n_last     = w_k;
            if (!w_mod && r_cnt != 8'sd127) n_cnt = r_cnt + 8'sd1;
            if (w_k == SC_CAPS) begin
                n_caps = ~r_caps;
            end else begin
                o_emit = (n_cnt == 8'sd1 || n_cnt == 8'sd2) && (w_k != '0);
            end
        end
    end

    // lookup sees the map with this press already set
    always_comb begin
        if (n_map[SC_LSHIFT] || n_map[SC_RSHIFT]) w_ch = SHIFT_MAP[w_k];
        else                                      w_ch = PLAIN_MAP[w_k];
        if (r_caps && w_ch >= 8'h61 && w_ch <= 8'h7A) w_ch = w_ch - 8'd32;
        if (n_map[SC_CTRL]) w_ch = w_ch & 8'd31;
    end

    assign o_char = w_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '0;
            r_last <= '0;
            r_cnt  <= '0;
            r_caps <= 1'b0;
        end else if (i_adv && i_key_evt) begin
            r_map  <= n_map;
            r_last <= n_last;
            r_cnt  <= n_cnt;
            r_caps <= n_caps;
        end
    end

endmodule

[sv/keyboard_packet_scancode_decoder_core.sv]
// Decodes the byte stream of a keyboard controller link. Packet headers
// (0xF6 and up) are framed and their bodies dropped; a finished status or
// clock reply gives a tuser=1 item with zero data. Other bytes are key
// presses/releases; a press with one or two ordinary keys held gives a
// tuser=0 item carrying the character. One byte per cycle is taken when not
// stalled; each byte passes the input register, then the result register,
// and the input stalls only while a result waits in the output register.
`include "keyboard_packet_scancode_decoder_core_assert.svh"
module keyboard_packet_scancode_decoder_core import kpsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] char_code
    output logic       m_axis_tuser    // [0] event_kind
);

    logic       r_in_vld;
    logic [7:0] r_in;
    logic       r_out_vld;
    logic [7:0] r_out_ch;
    logic       r_out_kind;
    logic       w_adv;
    t_frame_ev  w_ev;
    logic       w_emit;
    logic [7:0] w_ch;

    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    kpsd_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in),
        .o_ev    (w_ev)
    );

    kpsd_keymap u_keymap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_key_evt (w_ev.key_evt),
        .i_byte    (r_in),
        .o_emit    (w_emit),
        .o_char    (w_ch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_in <= s_axis_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && (w_ev.reply || (w_ev.key_evt && w_emit))) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_ev.reply) begin
            r_out_kind <= KIND_REPLY;
            r_out_ch   <= '0;
        end else if (w_adv && w_ev.key_evt && w_emit) begin
            r_out_kind <= KIND_CHAR;
            r_out_ch   <= w_ch;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_ch;
    assign m_axis_tuser  = r_out_kind;

    `KPSD_ASSERT_IMP(a_reply_zero, i_clk, i_rst_n, r_out_vld && r_out_kind == KIND_REPLY, r_out_ch == 8'd0)
    `KPSD_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !r_out_vld, s_axis_tready)
    `KPSD_ASSERT_IMP(a_ev_exclusive, i_clk, i_rst_n, r_in_vld, !(w_ev.key_evt && w_ev.reply))

endmodule
